// ===== hw/rtl/trp_pkg.sv =====
// Shared constants, codes and word types for the TFTP request option parser.
`timescale 1ns / 1ps

package trp_pkg;

  localparam int NAME_MAX_LEN = 256;
  localparam int LEN_W        = $clog2(NAME_MAX_LEN + 1);
  localparam int KEY_LEN      = 7;

  localparam int ACC_W = 17;
  localparam logic [ACC_W-1:0] ACC_MAX = 17'h1FFFF;
  // Largest accumulator that can take one more digit without passing ACC_MAX:
  // one bound for digits 0 and 1, another for digits 2 through 9.
  localparam logic [ACC_W-1:0] ACC_LIM_HI = ACC_W'(ACC_MAX / 10);
  localparam logic [ACC_W-1:0] ACC_LIM_LO = ACC_W'((ACC_MAX - 9) / 10);

  localparam logic [15:0] BLK_DEFAULT = 16'd512;
  localparam logic [15:0] BLK_MIN     = 16'd8;
  localparam logic [15:0] BLK_MAX     = 16'd65464;
  localparam logic [7:0]  TMO_DEFAULT = 8'd10;
  localparam logic [7:0]  TMO_MIN     = 8'd1;
  localparam logic [7:0]  TMO_MAX     = 8'd255;

  // Parser phases.
  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_FNAME  = 3'd1;
  localparam logic [2:0] PH_MODE   = 3'd2;
  localparam logic [2:0] PH_ONAME  = 3'd3;
  localparam logic [2:0] PH_OVAL   = 3'd4;
  localparam logic [2:0] PH_IDLE   = 3'd5;

  localparam logic [1:0] MODE_NETASCII = 2'd0;
  localparam logic [1:0] MODE_OCTET    = 2'd1;
  localparam logic [1:0] MODE_UNKNOWN  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FNAME  = 2'd1;
  localparam logic [1:0] ST_MODE   = 2'd2;

  localparam logic [1:0] OPT_NONE = 2'd0;
  localparam logic [1:0] OPT_BLK  = 2'd1;
  localparam logic [1:0] OPT_TMO  = 2'd2;

  localparam logic [1:0] MATCH_BOTH = 2'b11;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } trp_word_t;

  // Packed so that op_code lands in the lowest bits.
  typedef struct packed {
    logic [1:0]  parse_status;
    logic [7:0]  timeout_secs;
    logic        timeout_given;
    logic [15:0] blk_size;
    logic        blksize_given;
    logic [1:0]  transfer_mode;
    logic [8:0]  name_length;
    logic [7:0]  op_code;
  } trp_result_t;

endpackage

// ===== hw/rtl/tftp_request_option_parser.sv =====
// Top level of the TFTP request option parser: input stage, parser and result register.
`timescale 1ns / 1ps
// Usage:
//   The in_ channel carries a TFTP read or write request one byte per word, with
//   in_tlast high on the final byte. The out_ channel gives one summary word per
//   request: opcode, filename length, transfer mode, blksize and timeout values
//   with their presence flags, and a parse status.
//   Each byte is registered at the input; the parse logic updates the parser
//   state as the byte leaves that register, and the summary for a request
//   is written to the output register as its last byte leaves it. One byte
//   can be accepted every cycle, for as long as the output side keeps up.
//   The output register lets the next request's bytes flow while a summary
//   waits; only a last byte is held at the input stage while the previous
//   summary has not been taken, and then in_tready drops behind it.
//   Reset (rst_n low, synchronous) empties both registers and puts the parser
//   at the start of a request. After each last byte the parser starts over on
//   its own.
module tftp_request_option_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] req_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [7:0] op_code, [16:8] name_length,
                                  // [18:17] transfer_mode, [19] blksize_given,
                                  // [35:20] blk_size, [36] timeout_given,
                                  // [44:37] timeout_secs, [46:45] parse_status
);

  logic                 word_valid;
  trp_pkg::trp_word_t   word;
  logic                 out_free;
  logic                 take;
  logic                 step;
  logic                 res_valid;
  trp_pkg::trp_result_t res;
  logic                 out_valid_r;
  trp_pkg::trp_result_t out_res_r;

  assign out_free = !out_valid_r || out_tready;
  // Only a last word makes a result, so only it waits on the output register.
  assign take     = !word.last || out_free;
  assign step     = word_valid && take;

  trp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (take),
    .word_valid (word_valid),
    .word       (word)
  );

  trp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

  // A new summary never lands on one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !res_valid)
    else $error("summary produced while output register is stalled");

  a_blk_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.blk_size >= trp_pkg::BLK_MIN &&
                     out_res_r.blk_size <= trp_pkg::BLK_MAX))
    else $error("block size outside accepted range");

  a_tmo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.timeout_secs != 8'd0))
    else $error("timeout of zero seconds reported");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.parse_status == trp_pkg::ST_OK ||
                     out_res_r.parse_status == trp_pkg::ST_FNAME ||
                     out_res_r.parse_status == trp_pkg::ST_MODE))
    else $error("undefined parse status");

endmodule

// ===== hw/rtl/trp_in_reg.sv =====
// Input register stage: holds one accepted byte until the parser takes it.
`timescale 1ns / 1ps

module trp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // req_byte[7:0]
  input  logic              in_tlast,   // last_byte
  input  logic              take,       // parser can consume the held word
  output logic              word_valid,
  output trp_pkg::trp_word_t word
);

  logic               valid_r;
  trp_pkg::trp_word_t word_r;

  assign in_tready  = !valid_r || take;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      word_r.data <= in_tdata;
      word_r.last <= in_tlast;
    end
  end

endmodule

// ===== hw/rtl/trp_parse.sv =====
// Request parser: per-byte phase tracking, keyword match, value accumulate, summary.
`timescale 1ns / 1ps

module trp_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  trp_pkg::trp_word_t    word,
  output logic                  res_valid,
  output trp_pkg::trp_result_t  res
);

  localparam int LW = trp_pkg::LEN_W;
  localparam int AW = trp_pkg::ACC_W;

  function automatic logic [7:0] key_blk(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = "b";
      3'd1: c = "l";
      3'd2: c = "k";
      3'd3: c = "s";
      3'd4: c = "i";
      3'd5: c = "z";
      3'd6: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] key_tmo(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = "t";
      3'd1: c = "i";
      3'd2: c = "m";
      3'd3: c = "e";
      3'd4: c = "o";
      3'd5: c = "u";
      3'd6: c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // One decimal digit into the accumulator, saturating at ACC_MAX.
  function automatic logic [AW-1:0] acc_step(input logic [AW-1:0] acc,
                                             input logic [3:0] digit);
    logic [AW+3:0]   prod;
    logic [AW-1:0]   lim;
    lim  = (digit <= 4'd1) ? trp_pkg::ACC_LIM_HI : trp_pkg::ACC_LIM_LO;
    prod = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{AW{1'b0}}, digit};
    return (acc > lim) ? trp_pkg::ACC_MAX : prod[AW-1:0];
  endfunction

  function automatic logic [15:0] blk_pick(input logic [1:0] pend,
                                           input logic [AW-1:0] v,
                                           input logic [15:0] cur);
    logic [15:0] r;
    r = cur;
    if (pend == trp_pkg::OPT_BLK) begin
      r = (v >= AW'(trp_pkg::BLK_MIN) && v <= AW'(trp_pkg::BLK_MAX)) ?
          v[15:0] : trp_pkg::BLK_DEFAULT;
    end
    return r;
  endfunction

  function automatic logic [7:0] tmo_pick(input logic [1:0] pend,
                                          input logic [AW-1:0] v,
                                          input logic [7:0] cur);
    logic [7:0] r;
    r = cur;
    if (pend == trp_pkg::OPT_TMO) begin
      r = (v >= AW'(trp_pkg::TMO_MIN) && v <= AW'(trp_pkg::TMO_MAX)) ?
          v[7:0] : trp_pkg::TMO_DEFAULT;
    end
    return r;
  endfunction

  logic          pos1_r,     pos1_nxt;
  logic [2:0]    phase_r,    phase_nxt;
  logic [LW-1:0] len_r,      len_nxt;
  logic [7:0]    opcode_r,   opcode_nxt;
  logic [LW-1:0] nlen_r,     nlen_nxt;
  logic [1:0]    mode_r,     mode_nxt;
  logic [1:0]    match_r,    match_nxt;
  logic [1:0]    pend_r,     pend_nxt;
  logic [AW-1:0] acc_r,      acc_nxt;
  logic          stopped_r,  stopped_nxt;
  logic [15:0]   blk_r,      blk_nxt;
  logic [7:0]    tmo_r,      tmo_nxt;
  logic [1:0]    flags_r,    flags_nxt;
  logic [1:0]    err_r,      err_nxt;

  logic [7:0]    b;
  logic [LW-1:0] len_inc;
  logic [1:0]    pend_sel;

  assign b       = word.data;
  assign len_inc = len_r + LW'(1);

  always_comb begin
    pos1_nxt    = pos1_r;
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    opcode_nxt  = opcode_r;
    nlen_nxt    = nlen_r;
    mode_nxt    = mode_r;
    match_nxt   = match_r;
    pend_nxt    = pend_r;
    acc_nxt     = acc_r;
    stopped_nxt = stopped_r;
    blk_nxt     = blk_r;
    tmo_nxt     = tmo_r;
    flags_nxt   = flags_r;
    err_nxt     = err_r;
    pend_sel    = trp_pkg::OPT_NONE;

    if (step) begin
      unique case (phase_r)
        trp_pkg::PH_OPCODE: begin
          // Byte 0 is skipped; byte 1 carries the opcode's low byte.
          if (pos1_r) begin
            opcode_nxt = b;
            phase_nxt  = trp_pkg::PH_FNAME;
            len_nxt    = '0;
          end else begin
            pos1_nxt = 1'b1;
          end
        end
        trp_pkg::PH_FNAME: begin
          if (b == 8'h00) begin
            nlen_nxt  = len_r;
            phase_nxt = trp_pkg::PH_MODE;
            len_nxt   = '0;
          end else begin
            len_nxt = len_inc;
            if (len_inc >= LW'(trp_pkg::NAME_MAX_LEN)) begin
              nlen_nxt  = len_inc;
              err_nxt   = trp_pkg::ST_FNAME;
              phase_nxt = trp_pkg::PH_IDLE;
            end
          end
        end
        trp_pkg::PH_MODE: begin
          if (len_r == '0) begin
            mode_nxt = (b == "n") ? trp_pkg::MODE_NETASCII :
                       (b == "o") ? trp_pkg::MODE_OCTET : trp_pkg::MODE_UNKNOWN;
          end
          if (b == 8'h00) begin
            phase_nxt = trp_pkg::PH_ONAME;
            len_nxt   = '0;
            match_nxt = trp_pkg::MATCH_BOTH;
          end else begin
            len_nxt = len_inc;
            if (len_inc >= LW'(trp_pkg::NAME_MAX_LEN)) begin
              err_nxt   = trp_pkg::ST_MODE;
              phase_nxt = trp_pkg::PH_IDLE;
            end
          end
        end
        trp_pkg::PH_ONAME: begin
          if (b == 8'h00) begin
            if (len_r == '0) begin
              phase_nxt = trp_pkg::PH_IDLE;
            end else begin
              if (len_r >= LW'(trp_pkg::KEY_LEN)) begin
                if (match_r[0]) begin
                  pend_sel = trp_pkg::OPT_BLK;
                end else if (match_r[1]) begin
                  pend_sel = trp_pkg::OPT_TMO;
                end
              end
              pend_nxt    = pend_sel;
              flags_nxt   = flags_r | pend_sel;
              acc_nxt     = '0;
              stopped_nxt = 1'b0;
              phase_nxt   = trp_pkg::PH_OVAL;
            end
          end else if (len_r < LW'(trp_pkg::KEY_LEN)) begin
            // The name length only matters up to the keyword length.
            if (b != key_blk(len_r[2:0])) begin
              match_nxt[0] = 1'b0;
            end
            if (b != key_tmo(len_r[2:0])) begin
              match_nxt[1] = 1'b0;
            end
            len_nxt = len_inc;
          end
        end
        trp_pkg::PH_OVAL: begin
          if (b == 8'h00) begin
            blk_nxt   = blk_pick(pend_r, acc_r, blk_r);
            tmo_nxt   = tmo_pick(pend_r, acc_r, tmo_r);
            pend_nxt  = trp_pkg::OPT_NONE;
            len_nxt   = '0;
            match_nxt = trp_pkg::MATCH_BOTH;
            phase_nxt = trp_pkg::PH_ONAME;
          end else if (!stopped_r) begin
            if (b >= "0" && b <= "9") begin
              acc_nxt = acc_step(acc_r, 4'(b - "0"));
            end else begin
              stopped_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Summary on the last word, built from the state after that word.
  always_comb begin
    res.op_code       = opcode_nxt;
    res.name_length   = 9'((phase_nxt == trp_pkg::PH_FNAME) ? len_nxt : nlen_nxt);
    res.transfer_mode = mode_nxt;
    res.blksize_given = flags_nxt[0];
    res.timeout_given = flags_nxt[1];
    // A value still open at the end of the packet is applied as it stands.
    if (phase_nxt == trp_pkg::PH_OVAL) begin
      res.blk_size     = blk_pick(pend_nxt, acc_nxt, blk_nxt);
      res.timeout_secs = tmo_pick(pend_nxt, acc_nxt, tmo_nxt);
    end else begin
      res.blk_size     = blk_nxt;
      res.timeout_secs = tmo_nxt;
    end
    priority if (err_nxt != trp_pkg::ST_OK) begin
      res.parse_status = err_nxt;
    end else if (phase_nxt == trp_pkg::PH_OPCODE || phase_nxt == trp_pkg::PH_FNAME) begin
      res.parse_status = trp_pkg::ST_FNAME;
    end else if (phase_nxt == trp_pkg::PH_MODE) begin
      res.parse_status = trp_pkg::ST_MODE;
    end else begin
      res.parse_status = trp_pkg::ST_OK;
    end
  end

  assign res_valid = step && word.last;

  // The parser returns to its reset state after each packet's last word.
  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      pos1_r    <= 1'b0;
      phase_r   <= trp_pkg::PH_OPCODE;
      len_r     <= '0;
      opcode_r  <= '0;
      nlen_r    <= '0;
      mode_r    <= trp_pkg::MODE_UNKNOWN;
      match_r   <= trp_pkg::MATCH_BOTH;
      pend_r    <= trp_pkg::OPT_NONE;
      acc_r     <= '0;
      stopped_r <= 1'b0;
      blk_r     <= trp_pkg::BLK_DEFAULT;
      tmo_r     <= trp_pkg::TMO_DEFAULT;
      flags_r   <= '0;
      err_r     <= trp_pkg::ST_OK;
    end else begin
      pos1_r    <= pos1_nxt;
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      opcode_r  <= opcode_nxt;
      nlen_r    <= nlen_nxt;
      mode_r    <= mode_nxt;
      match_r   <= match_nxt;
      pend_r    <= pend_nxt;
      acc_r     <= acc_nxt;
      stopped_r <= stopped_nxt;
      blk_r     <= blk_nxt;
      tmo_r     <= tmo_nxt;
      flags_r   <= flags_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the TFTP request option parser, with its own predictor.
`timescale 1ns / 1ps

module testbench;
  import trp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_BYTES   = 120;
  localparam int PRINT_LIMIT    = 200;
  localparam logic [8*KEY_LEN-1:0] BLK_KEY = "blksize";
  localparam logic [8*KEY_LEN-1:0] TMO_KEY = "timeout";

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  tftp_request_option_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  trp_result_t expected_summaries[$];
  logic [7:0]  pkt[$];
  int          mismatch_count;
  int          bytes_sent;
  int          quiet_cycles;
  bit          steady_flow;

  // Predicted parser state.
  int         prs_pos;
  logic [2:0] prs_phase;
  int         prs_len;
  logic [7:0] prs_opcode;
  int         prs_name_len;
  logic [1:0] prs_mode;
  logic [1:0] prs_match;
  logic [1:0] prs_pending;
  int         prs_acc;
  bit         prs_stopped;
  int         prs_blk;
  int         prs_tmo;
  logic [1:0] prs_flags;
  logic [1:0] prs_err;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void clear_parser();
    prs_pos      = 0;
    prs_phase    = PH_OPCODE;
    prs_len      = 0;
    prs_opcode   = '0;
    prs_name_len = 0;
    prs_mode     = MODE_UNKNOWN;
    prs_match    = MATCH_BOTH;
    prs_pending  = OPT_NONE;
    prs_acc      = 0;
    prs_stopped  = 1'b0;
    prs_blk      = int'(BLK_DEFAULT);
    prs_tmo      = int'(TMO_DEFAULT);
    prs_flags    = '0;
    prs_err      = ST_OK;
  endfunction

  function automatic void apply_option_value();
    if (prs_pending == OPT_BLK) begin
      prs_blk = (prs_acc >= int'(BLK_MIN) && prs_acc <= int'(BLK_MAX)) ?
                prs_acc : int'(BLK_DEFAULT);
    end else if (prs_pending == OPT_TMO) begin
      prs_tmo = (prs_acc >= int'(TMO_MIN) && prs_acc <= int'(TMO_MAX)) ?
                prs_acc : int'(TMO_DEFAULT);
    end
  endfunction

  function automatic void parse_request_byte(input logic [7:0] b, input logic last);
    int          d;
    trp_result_t r;
    case (prs_phase)
      PH_OPCODE: begin
        if (prs_pos == 1) begin
          prs_opcode = b;
          prs_phase  = PH_FNAME;
          prs_len    = 0;
        end
      end
      PH_FNAME: begin
        if (b == 8'h00) begin
          prs_name_len = prs_len;
          prs_phase    = PH_MODE;
          prs_len      = 0;
        end else begin
          prs_len++;
          if (prs_len >= NAME_MAX_LEN) begin
            prs_name_len = prs_len;
            prs_err      = ST_FNAME;
            prs_phase    = PH_IDLE;
          end
        end
      end
      PH_MODE: begin
        if (prs_len == 0) begin
          prs_mode = (b == "n") ? MODE_NETASCII : (b == "o") ? MODE_OCTET : MODE_UNKNOWN;
        end
        if (b == 8'h00) begin
          prs_phase = PH_ONAME;
          prs_len   = 0;
          prs_match = MATCH_BOTH;
        end else begin
          prs_len++;
          if (prs_len >= NAME_MAX_LEN) begin
            prs_err   = ST_MODE;
            prs_phase = PH_IDLE;
          end
        end
      end
      PH_ONAME: begin
        if (b == 8'h00) begin
          if (prs_len == 0) begin
            prs_phase = PH_IDLE;
          end else begin
            prs_pending = OPT_NONE;
            if (prs_len >= KEY_LEN) begin
              if (prs_match[0]) prs_pending = OPT_BLK;
              else if (prs_match[1]) prs_pending = OPT_TMO;
            end
            if (prs_pending == OPT_BLK) prs_flags[0] = 1'b1;
            if (prs_pending == OPT_TMO) prs_flags[1] = 1'b1;
            prs_acc     = 0;
            prs_stopped = 1'b0;
            prs_phase   = PH_OVAL;
          end
        end else begin
          // Only the first seven name bytes decide which keyword is meant.
          if (prs_len < KEY_LEN) begin
            if (b != BLK_KEY[8*(KEY_LEN-1-prs_len) +: 8]) prs_match[0] = 1'b0;
            if (b != TMO_KEY[8*(KEY_LEN-1-prs_len) +: 8]) prs_match[1] = 1'b0;
          end
          if (prs_len < 65535) prs_len++;
        end
      end
      PH_OVAL: begin
        if (b == 8'h00) begin
          apply_option_value();
          prs_pending = OPT_NONE;
          prs_len     = 0;
          prs_match   = MATCH_BOTH;
          prs_phase   = PH_ONAME;
        end else if (!prs_stopped) begin
          if (b >= "0" && b <= "9") begin
            d = int'(b) - int'("0");
            if (prs_acc > (int'(ACC_MAX) - d) / 10) prs_acc = int'(ACC_MAX);
            else prs_acc = prs_acc * 10 + d;
          end else begin
            prs_stopped = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (prs_pos < 65535) prs_pos++;

    if (last) begin
      if (prs_phase == PH_OVAL) apply_option_value();
      if (prs_err != ST_OK) r.parse_status = prs_err;
      else if (prs_phase == PH_OPCODE || prs_phase == PH_FNAME) r.parse_status = ST_FNAME;
      else if (prs_phase == PH_MODE) r.parse_status = ST_MODE;
      else r.parse_status = ST_OK;
      r.op_code       = prs_opcode;
      r.name_length   = (prs_phase == PH_FNAME) ? 9'(prs_len) : 9'(prs_name_len);
      r.transfer_mode = prs_mode;
      r.blksize_given = prs_flags[0];
      r.blk_size      = 16'(prs_blk);
      r.timeout_given = prs_flags[1];
      r.timeout_secs  = 8'(prs_tmo);
      expected_summaries.push_back(r);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string field, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
  endtask

  task automatic check_summary(input trp_result_t got);
    trp_result_t want;
    if (expected_summaries.size() == 0) begin
      report_mismatch($sformatf("summary word 0x%012h with no request pending", out_tdata));
    end else begin
      want = expected_summaries.pop_front();
      compare_field("op_code", got.op_code, want.op_code);
      compare_field("name_length", got.name_length, want.name_length);
      compare_field("transfer_mode", got.transfer_mode, want.transfer_mode);
      compare_field("blksize_given", got.blksize_given, want.blksize_given);
      compare_field("blk_size", got.blk_size, want.blk_size);
      compare_field("timeout_given", got.timeout_given, want.timeout_given);
      compare_field("timeout_secs", got.timeout_secs, want.timeout_secs);
      compare_field("parse_status", got.parse_status, want.parse_status);
    end
  endtask

  // Results are checked before the same edge's input word is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_summary(trp_result_t'(out_tdata[46:0]));
      if (in_tvalid && in_tready) parse_request_byte(in_tdata, in_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tftp_request_option_parser: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= 14);
  end

  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady_flow && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    bytes_sent += pkt.size();
    pkt.delete();
  endtask

  task automatic wait_for_summaries();
    in_tvalid <= 1'b0;
    while (expected_summaries.size() != 0) @(negedge clk);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endfunction

  function automatic void add_zero();
    pkt.push_back(8'h00);
  endfunction

  function automatic void add_noise(input int n, input bit allow_zero);
    repeat (n) pkt.push_back(8'($urandom_range(255, allow_zero ? 0 : 1)));
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) pkt.push_back(8'($urandom_range("9", "0")));
  endfunction

  function automatic void start_request(input logic [7:0] op, input string fname,
                                        input string mode);
    pkt.push_back(8'h00);
    pkt.push_back(op);
    add_text(fname);
    add_zero();
    add_text(mode);
    add_zero();
  endfunction

  function automatic void add_option(input string name, input string value);
    add_text(name);
    add_zero();
    add_text(value);
    add_zero();
  endfunction

  function automatic void add_random_name();
    string s;
    case ($urandom_range(7))
      0: add_text("blksize");
      1: add_text("timeout");
      2: begin add_text("blksize"); add_noise($urandom_range(3, 1), 1'b0); end
      3: begin add_text("timeout"); add_noise($urandom_range(3, 1), 1'b0); end
      4: add_text("blksiz");
      5: add_text("timeou");
      6: add_noise($urandom_range(9, 1), 1'b0);
      default: begin
        // One byte off from a keyword.
        s = $urandom_range(1) ? "blksize" : "timeout";
        s[$urandom_range(KEY_LEN - 1)] = 8'($urandom_range(255, 1));
        add_text(s);
      end
    endcase
  endfunction

  function automatic void add_random_value();
    int edges[14] = '{0, 1, 7, 8, 9, 254, 255, 256, 65463, 65464, 65465,
                      131070, 131071, 131072};
    case ($urandom_range(9))
      0: add_text($sformatf("%0d", $urandom_range(65464, 8)));
      1: add_text($sformatf("%0d", $urandom_range(255, 1)));
      2: add_text($sformatf("%0d", edges[$urandom_range(13)]));
      3: add_digits($urandom_range(12, 1));
      4: ;
      5: begin add_digits($urandom_range(4, 1)); add_noise($urandom_range(3, 1), 1'b0); end
      6: add_noise($urandom_range(4, 1), 1'b0);
      7: add_text($sformatf("%0d", $urandom_range(1000)));
      8: add_text($sformatf("000%0d", $urandom_range(300)));
      default: add_text($sformatf("%0d", $urandom_range(200000)));
    endcase
  endfunction

  function automatic void build_random_request();
    int n_opts;
    pkt.push_back(8'($urandom_range(255)));
    pkt.push_back($urandom_range(3) != 0 ? 8'($urandom_range(2, 1)) : 8'($urandom_range(255)));
    add_noise($urandom_range(12), 1'b0);
    add_zero();
    case ($urandom_range(4))
      0, 1: add_text("netascii");
      2, 3: add_text("octet");
      default: add_noise($urandom_range(6), 1'b0);
    endcase
    add_zero();
    n_opts = $urandom_range(4);
    repeat (n_opts) begin
      add_random_name();
      add_zero();
      add_random_value();
      add_zero();
    end
  endfunction

  task automatic test_short_requests();
    pkt = '{8'h00};
    send_packet();
    pkt = '{8'h00, 8'hFF};
    send_packet();
    pkt = '{8'h00, 8'h01, "f", 8'h00, "n"};
    send_packet();
    pkt = '{8'h00, 8'h01, "a", 8'h00};
    send_packet();
    start_request(8'h02, "ab", "octet");
    send_packet();
    start_request(8'h01, "", "");
    send_packet();
    start_request(8'h01, "x", "netascii");
    add_option("blksize", "8");
    add_option("timeout", "1");
    send_packet();
    start_request(8'h00, "file.bin", "o");
    add_option("blksize", "65464");
    add_option("timeout", "255");
    send_packet();
    start_request(8'hFF, "y", "octet");
    add_option("blksize", "7");
    add_option("timeout", "0");
    send_packet();
    start_request(8'h02, "z", "octet");
    add_option("blksize", "65465");
    add_option("timeout", "256");
    send_packet();
    start_request(8'h01, "q", "netascii");
    add_option("blksize", "99999999999");
    add_option("timeout", "12abc");
    send_packet();
    start_request(8'h01, "q", "netascii");
    add_option("blksize", "");
    add_option("timeout", "x5");
    send_packet();
    // Longer names still match on their first seven bytes, shorter ones never.
    start_request(8'h01, "r", "octet");
    add_option("blksizeXYZ", "1024");
    add_option("timeou", "5");
    add_option("blksiz", "9");
    send_packet();
    start_request(8'h02, "s", "octet");
    add_option("blksize", "100");
    add_option("blksize", "2000");
    add_option("timeout", "3");
    add_option("timeout", "7");
    send_packet();
    start_request(8'h01, "t", "octet");
    add_text("timeout");
    add_zero();
    add_text("42");
    send_packet();
    start_request(8'h01, "u", "octet");
    add_text("blksize");
    send_packet();
    start_request(8'h01, "v", "octet");
    add_text("blksize");
    add_zero();
    send_packet();
    // An empty option name ends option parsing.
    start_request(8'h01, "w", "octet");
    add_zero();
    add_option("blksize", "100");
    send_packet();
    start_request(8'h01, "NAME", "NETASCII");
    add_option("BLKSIZE", "64");
    add_text("timeout");
    add_zero();
    pkt.push_back(8'hFF);
    add_text("9");
    add_zero();
    add_option("blksize", "0000016");
    send_packet();
    wait_for_summaries();
    @(negedge clk);
  endtask

  task automatic test_name_limits();
    steady_flow = 1'b1;
    // Longest filename that still fits, then one that never ends, then a mode that never ends.
    pkt = '{8'h00, 8'h01};
    add_noise(NAME_MAX_LEN - 1, 1'b0);
    add_zero();
    add_text("octet");
    add_zero();
    add_option("timeout", "30");
    send_packet();
    pkt = '{8'h00, 8'h02};
    add_noise(NAME_MAX_LEN, 1'b0);
    add_noise(6, 1'b1);
    add_zero();
    send_packet();
    start_request(8'h01, "m", "");
    void'(pkt.pop_back());
    add_noise(NAME_MAX_LEN, 1'b0);
    add_noise(4, 1'b1);
    send_packet();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_requests();
    int start_bytes;
    int n_pkts;
    int cut;
    start_bytes = bytes_sent;
    n_pkts = 0;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      case ($urandom_range(99)) inside
        [0:69]: build_random_request();
        [70:81]: begin
          build_random_request();
          cut = $urandom_range(pkt.size(), 1);
          pkt = pkt[0:cut-1];
        end
        [82:91]: add_noise($urandom_range(24, 1), 1'b1);
        default: begin
          build_random_request();
          add_zero();
          add_noise($urandom_range(10, 1), 1'b1);
        end
      endcase
      send_packet();
      n_pkts++;
      if (n_pkts % 5 == 0) begin
        wait_for_summaries();
        @(negedge clk);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    steady_flow    = 1'b0;
    mismatch_count = 0;
    bytes_sent     = 0;
    quiet_cycles   = 0;
    clear_parser();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_requests();
    test_name_limits();
    test_random_requests();

    wait_for_summaries();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_summaries.size() == 0) begin
      $display("tftp_request_option_parser: match");
    end else begin
      $display("tftp_request_option_parser: mismatch");
    end
    $finish;
  end

endmodule
